// ----- sv/vfdpg_pkg.sv -----
// Package for the pixel to graphics RAM writer: payload structs, codes,
// pixel placement tables and the memory request type.
// No dependencies; every module of the block imports it.
`default_nettype none

package vfdpg_pkg;

    // Frame store geometry.
    localparam int RAM_BYTES = 1024;
    localparam int GRAM_AW   = $clog2(RAM_BYTES);
    // Width of the draw address arithmetic; holds any value up to 8191.
    localparam int CALC_W    = 13;

    // Base address folding thresholds and steps.
    localparam logic [CALC_W-1:0] BASE_HI_LIMIT = CALC_W'(480);
    localparam logic [CALC_W-1:0] BASE_LO_LIMIT = CALC_W'(256);
    localparam logic [CALC_W-1:0] BASE_HI_STEP  = CALC_W'(32);
    localparam logic [CALC_W-1:0] BASE_LO_STEP  = CALC_W'(16);
    localparam logic [CALC_W-1:0] BASE_START    = CALC_W'(2);

    // Division by three of an 8-bit column: (x * 171) >> 9 is exact below 512.
    localparam logic [15:0] DIV3_MUL   = 16'd171;
    localparam int          DIV3_SHIFT = 9;

    // Action codes.
    localparam logic [1:0] ACT_DRAW  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Status codes.
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] pixel_x;
        logic [4:0] pixel_y;
        logic       dot_on;
        logic [9:0] byte_address;
        logic [7:0] byte_value;
    } vfdpg_in_t;

    // Result transaction.
    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } vfdpg_out_t;

    // One request to the frame store.
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [GRAM_AW-1:0] addr;
        logic [7:0]         wr_data;
    } gram_req_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_PLACE,
        ST_READ,
        ST_MODIFY,
        ST_ACCESS,
        ST_FETCH,
        ST_DONE
    } vfdpg_state_t;

    // Placement table: index parity*12 + phase*3 + group bit,
    // value is byte offset * 8 + bit number.
    localparam logic [4:0] BIT_PLACE [0:23] = '{
        5'd2,  5'd3,  5'd4,
        5'd12, 5'd13, 5'd14,
        5'd22, 5'd23, 5'd8,
        5'd16, 5'd17, 5'd18,
        5'd5,  5'd6,  5'd7,
        5'd15, 5'd0,  5'd1,
        5'd9,  5'd10, 5'd11,
        5'd19, 5'd20, 5'd21
    };

    // Group bit chosen by the column remainder, per parity.
    localparam logic [1:0] GROUP_BIT [0:5] = '{
        2'd1, 2'd0, 2'd2,
        2'd1, 2'd2, 2'd0
    };

    // Byte offset and bit number of one pixel inside its group.
    function automatic logic [4:0] pixel_place(input logic par, input logic [1:0] phase,
                                               input logic [1:0] rem);
        logic [2:0] gidx;
        logic [1:0] g;
        logic [4:0] pidx;
        gidx = 3'(3 * int'(par) + int'(rem));
        g    = GROUP_BIT[gidx];
        pidx = 5'(12 * int'(par) + 3 * int'(phase) + int'(g));
        return BIT_PLACE[pidx];
    endfunction

endpackage

`default_nettype wire

// ----- sv/vfd_pixel_to_gram_writer_unit.sv -----
// Top level of the pixel to graphics RAM writer: handshakes, sequencer and
// pixel address arithmetic. Depends on vfdpg_pkg and vfdpg_gram.
//
//   Channel   Ports                        Payload       Direction
//   input     s_valid, s_ready, s_data     vfdpg_in_t    in
//   result    m_valid, m_ready, m_data     vfdpg_out_t   out
//
// A draw passes through split, place, read, modify and done, a byte read
// through access, fetch and done, a byte write through access and done and an
// unused action straight to done. The single frame store port makes a draw a
// read then a write. After reset the frame store clears all RAM_BYTES (1024)
// entries while s_ready stays low. A result waits in its output register while the next
// transaction is accepted; the sequencer only stalls in its done state.
`default_nettype none

module vfd_pixel_to_gram_writer_unit
    import vfdpg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire vfdpg_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output vfdpg_out_t      m_data
);

    vfdpg_state_t      state_reg, state_next;
    vfdpg_in_t         item_reg, item_next;
    logic [6:0]        col_reg, col_next;
    logic [1:0]        rem_reg, rem_next;
    logic [CALC_W-1:0] addr_reg, addr_next;
    logic [2:0]        bit_reg, bit_next;
    vfdpg_out_t        res_reg, res_next;
    vfdpg_out_t        out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    gram_req_t         gram_req;
    logic [7:0]        gram_rd_data;
    logic              gram_busy;

    logic [15:0]       div_prod;
    logic [6:0]        div_col;
    logic [7:0]        div_rem;
    logic [CALC_W-1:0] base_raw;
    logic [CALC_W-1:0] base_adj;
    logic [4:0]        place;
    logic [CALC_W-1:0] placed_addr;
    logic [7:0]        bit_mask;

    vfdpg_gram u_gram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (gram_req),
        .rd_data (gram_rd_data),
        .busy    (gram_busy)
    );

    // Column split: x / 3 by reciprocal multiply, remainder by subtraction.
    always_comb begin
        div_prod = 16'(item_reg.pixel_x) * DIV3_MUL;
        div_col  = div_prod[DIV3_SHIFT +: 7];
        div_rem  = item_reg.pixel_x - ({div_col, 1'b0} + 8'(div_col));
    end

    // Base address with folding, then the bit placement inside the group.
    always_comb begin
        base_raw = BASE_START + CALC_W'({col_reg, 4'b0000})
                   + CALC_W'(item_reg.pixel_y[4:2]) * CALC_W'(3);
        if (base_raw > BASE_HI_LIMIT) begin
            base_adj = base_raw + BASE_HI_STEP;
        end else if (base_raw > BASE_LO_LIMIT) begin
            base_adj = base_raw + BASE_LO_STEP;
        end else begin
            base_adj = base_raw;
        end
        place       = pixel_place(col_reg[0], item_reg.pixel_y[1:0], rem_reg);
        placed_addr = base_adj + CALC_W'(place[4:3]);
        bit_mask    = 8'(1) << bit_reg;
    end

    // Sequencer: next state, frame store requests and result assembly.
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        col_next     = col_reg;
        rem_next     = rem_reg;
        addr_next    = addr_reg;
        bit_next     = bit_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        gram_req     = '0;
        s_ready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = !gram_busy;
                if (s_valid && !gram_busy) begin
                    item_next = s_data;
                    res_next  = '0;
                    case (s_data.action)
                        ACT_DRAW:  state_next = ST_SPLIT;
                        ACT_WRITE: state_next = ST_ACCESS;
                        ACT_READ:  state_next = ST_ACCESS;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SPLIT: begin
                col_next   = div_col;
                rem_next   = div_rem[1:0];
                state_next = ST_PLACE;
            end
            ST_PLACE: begin
                addr_next = placed_addr;
                bit_next  = place[2:0];
                if (placed_addr >= CALC_W'(RAM_BYTES)) begin
                    res_next.status = STATUS_RANGE;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                gram_req.rd_en = 1'b1;
                gram_req.addr  = addr_reg[GRAM_AW-1:0];
                state_next     = ST_MODIFY;
            end
            ST_MODIFY: begin
                gram_req.wr_en   = 1'b1;
                gram_req.addr    = addr_reg[GRAM_AW-1:0];
                gram_req.wr_data = item_reg.dot_on ? (gram_rd_data | bit_mask)
                                                   : (gram_rd_data & ~bit_mask);
                state_next       = ST_DONE;
            end
            ST_ACCESS: begin
                gram_req.addr    = GRAM_AW'(item_reg.byte_address);
                gram_req.wr_data = item_reg.byte_value;
                if (CALC_W'(item_reg.byte_address) >= CALC_W'(RAM_BYTES)) begin
                    res_next.status = STATUS_RANGE;
                    state_next      = ST_DONE;
                end else if (item_reg.action == ACT_WRITE) begin
                    gram_req.wr_en = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    gram_req.rd_en = 1'b1;
                    state_next     = ST_FETCH;
                end
            end
            ST_FETCH: begin
                res_next.read_data = gram_rd_data;
                state_next         = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        col_reg  <= col_next;
        rem_reg  <= rem_next;
        addr_reg <= addr_next;
        bit_reg  <= bit_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // No transaction is taken while the frame store is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !gram_busy)
        else $error("input accepted during frame store clearing");

    // The frame store is written only by a draw write-back or a byte write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        gram_req.wr_en |-> (state_reg == ST_MODIFY || state_reg == ST_ACCESS))
        else $error("frame store written outside a write step");

    // An out-of-range result never carries read data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_RANGE) |-> (m_data.read_data == 8'd0))
        else $error("out-of-range result with nonzero read data");

    // An accepted transaction always starts work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction did not start");

endmodule

`default_nettype wire

// ----- sv/vfdpg_gram.sv -----
// Frame store of the pixel writer: single-port byte RAM with registered read
// and a clearing pass after reset. Depends on vfdpg_pkg.
`default_nettype none

module vfdpg_gram
    import vfdpg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire gram_req_t  req,
    output logic [7:0]      rd_data,
    output logic            busy
);

    logic [7:0]         mem [0:RAM_BYTES-1];
    logic [GRAM_AW-1:0] clr_idx_reg;
    logic [GRAM_AW-1:0] clr_idx_next;
    logic               busy_reg;
    logic               busy_next;
    logic [7:0]         rd_data_reg;

    // Clearing pass walks every entry once after reset.
    always_comb begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg) begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == GRAM_AW'(RAM_BYTES - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end else begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    // Storage: zeros while clearing, otherwise the requested write.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire
